// ----- rtl/mnp_pkg.sv -----
package mnp_pkg;

  localparam int KEY_SPACE = 4096;
  localparam int KEY_BITS  = $clog2(KEY_SPACE);
  localparam int KEY_W     = 12;
  localparam int POS_BITS  = 40;

  localparam int ENTRY_W     = 1 + 8 + POS_BITS;
  localparam int IN_FIELDS_W = 24 + POS_BITS;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 5 + 8 + 8 + 2 * POS_BITS;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic [7:0] STAT_NOTE_OFF  = 8'h80;
  localparam logic [7:0] STAT_NOTE_ON   = 8'h90;
  localparam logic [7:0] STAT_CTRL_CHG  = 8'hB0;
  localparam logic [7:0] STAT_CHAN_MASK = 8'h0F;
  localparam logic [7:0] STAT_TYPE_MASK = 8'hF0;
  localparam logic [7:0] STAT_SYSTEM    = 8'hF0;

  typedef enum logic [1:0] {
    RK_NOTE = 2'd0,
    RK_CC   = 2'd1,
    RK_DONE = 2'd2
  } rkind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVT,
    ST_SCAN
  } state_t;

  typedef enum logic [1:0] {
    CLS_DROP,
    CLS_CC,
    CLS_ON,
    CLS_OFF
  } cls_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_CC,
    EMIT_NOTE,
    EMIT_FLUSH,
    EMIT_DONE
  } emit_t;

  typedef struct packed {
    logic  capture;
    logic  scan_next;
    logic  clr_step;
    logic  wr_on;
    logic  wr_free_evt;
    logic  wr_free_scan;
    emit_t emit;
  } mnp_cmd_t;

  typedef struct packed {
    logic in_flush;
    cls_t cls;
    logic hit;
    logic ptr_last;
    logic out_free;
  } mnp_stat_t;

endpackage

// ----- rtl/mnp_datapath.sv -----
module mnp_datapath
  import mnp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   cfg_valid,
  input  logic [POS_BITS-1:0]    cfg_data,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser,
  input  mnp_cmd_t               cmd,
  output mnp_stat_t              st
);

  logic [POS_BITS-1:0] take_r;
  logic [7:0]          status_r;
  logic [7:0]          d1_r;
  logic [7:0]          d2_r;
  logic [POS_BITS-1:0] pos_r;
  logic [KEY_BITS-1:0] scan_r;
  logic [KEY_BITS-1:0] scan_nxt;
  logic [KEY_BITS-1:0] cursor_r;
  logic [ENTRY_W-1:0]  rd_q;

  logic                out_valid_r;
  rkind_t              out_kind_r;
  logic [4:0]          out_chan_r;
  logic [7:0]          out_num_r;
  logic [7:0]          out_amt_r;
  logic [POS_BITS-1:0] out_start_r;
  logic [POS_BITS-1:0] out_dur_r;

  logic [ENTRY_W-1:0]  mem [KEY_SPACE];

  logic [7:0]          in_status;
  logic [7:0]          in_d1;
  logic [KEY_W-1:0]    key_in;
  logic [KEY_W-1:0]    key_r;
  logic [KEY_W-1:0]    note_key;
  logic                rd_en;
  logic [KEY_BITS-1:0] rd_addr;
  logic                wr_en;
  logic [KEY_BITS-1:0] wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic [POS_BITS-1:0] len;
  logic [7:0]          typ;
  logic                voice_ok;
  logic                pos_ok;
  logic                key_ok;
  cls_t                cls;
  logic [POS_BITS-1:0] held_start;
  logic [7:0]          held_vel;
  logic [POS_BITS-1:0] dur_end;
  logic [POS_BITS-1:0] dur;
  logic                ptr_last;

  assign in_status = in_tdata[7:0];
  assign in_d1     = in_tdata[15:8];
  assign key_in    = {in_status[3:0], in_d1};
  assign key_r     = {status_r[3:0], d1_r};

  assign ptr_last  = (scan_r == KEY_BITS'(KEY_SPACE - 1));
  assign scan_nxt  = ptr_last ? '0 : scan_r + KEY_BITS'(1);

  // table port control
  assign rd_en   = cmd.capture | cmd.scan_next;
  assign rd_addr = cmd.capture ? (in_tuser ? cursor_r : key_in[KEY_BITS-1:0]) : scan_nxt;
  assign wr_en   = cmd.clr_step | cmd.wr_on | cmd.wr_free_evt | cmd.wr_free_scan;
  assign wr_addr = (cmd.wr_on | cmd.wr_free_evt) ? key_r[KEY_BITS-1:0] : scan_r;
  assign wr_data = cmd.wr_on ? {1'b1, d2_r, pos_r} : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      status_r <= in_tdata[7:0];
      d1_r     <= in_tdata[15:8];
      d2_r     <= in_tdata[23:16];
      pos_r    <= in_tdata[24 +: POS_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      take_r   <= POS_BITS'(1);
      scan_r   <= '0;
      cursor_r <= '0;
    end else begin
      if (cfg_valid) begin
        take_r <= cfg_data;
      end
      if (cmd.capture && in_tuser) begin
        scan_r <= cursor_r;
      end else if (cmd.clr_step || cmd.scan_next) begin
        scan_r <= scan_nxt;
      end
      if (cmd.emit == EMIT_FLUSH) begin
        cursor_r <= scan_nxt;
      end else if (cmd.emit == EMIT_DONE) begin
        cursor_r <= '0;
      end
    end
  end

  // event classification on the captured beat
  assign len      = (take_r == '0) ? POS_BITS'(1) : take_r;
  assign typ      = status_r & STAT_TYPE_MASK;
  assign voice_ok = status_r[7] && (typ != STAT_SYSTEM);
  assign pos_ok   = !pos_r[POS_BITS-1] && (pos_r < len);
  assign key_ok   = ({1'b0, key_r} < (KEY_W + 1)'(KEY_SPACE));

  always_comb begin
    priority if (!voice_ok || !pos_ok) begin
      cls = CLS_DROP;
    end else if (typ == STAT_CTRL_CHG) begin
      cls = CLS_CC;
    end else if ((typ == STAT_NOTE_ON || typ == STAT_NOTE_OFF) && key_ok) begin
      cls = (typ == STAT_NOTE_ON && d2_r != 8'd0) ? CLS_ON : CLS_OFF;
    end else begin
      cls = CLS_DROP;
    end
  end

  assign held_start = rd_q[POS_BITS-1:0];
  assign held_vel   = rd_q[POS_BITS +: 8];

  // note-off runs to its own position, flush runs to the take end
  assign dur_end = (cmd.emit == EMIT_FLUSH) ? len : pos_r;
  assign dur     = (dur_end > held_start) ? dur_end - held_start : POS_BITS'(1);
  assign note_key = (cmd.emit == EMIT_FLUSH) ? KEY_W'(scan_r) : key_r;

  assign st.in_flush = in_tuser;
  assign st.cls      = cls;
  assign st.hit      = rd_q[ENTRY_W-1];
  assign st.ptr_last = ptr_last;
  assign st.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.emit)
      EMIT_CC: begin
        out_kind_r  <= RK_CC;
        out_chan_r  <= {1'b0, status_r[3:0]} + 5'd1;
        out_num_r   <= d1_r;
        out_amt_r   <= d2_r;
        out_start_r <= pos_r;
        out_dur_r   <= '0;
      end
      EMIT_NOTE, EMIT_FLUSH: begin
        out_kind_r  <= RK_NOTE;
        out_chan_r  <= {1'b0, note_key[11:8]} + 5'd1;
        out_num_r   <= note_key[7:0];
        out_amt_r   <= held_vel;
        out_start_r <= held_start;
        out_dur_r   <= dur;
      end
      EMIT_DONE: begin
        out_kind_r  <= RK_DONE;
        out_chan_r  <= '0;
        out_num_r   <= '0;
        out_amt_r   <= '0;
        out_start_r <= '0;
        out_dur_r   <= '0;
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_dur_r, out_start_r, out_amt_r, out_num_r,
                       out_chan_r};

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit != EMIT_NONE |=> out_valid_r)
    else $error("result beat not registered");

  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("table read and write in the same cycle");

  a_done_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit == EMIT_DONE |=> cursor_r == '0)
    else $error("flush cursor not rewound after done");

endmodule

// ----- rtl/mnp_ctrl.sv -----
module mnp_ctrl
  import mnp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  mnp_stat_t st,
  output mnp_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.emit  = EMIT_NONE;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.ptr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = st.in_flush ? ST_SCAN : ST_EVT;
        end
      end
      ST_EVT: begin
        unique case (st.cls)
          CLS_DROP: begin
            state_nxt = ST_IDLE;
          end
          CLS_CC: begin
            if (st.out_free) begin
              cmd.emit  = EMIT_CC;
              state_nxt = ST_IDLE;
            end
          end
          CLS_ON: begin
            cmd.wr_on = 1'b1;
            state_nxt = ST_IDLE;
          end
          CLS_OFF: begin
            if (!st.hit) begin
              state_nxt = ST_IDLE;
            end else if (st.out_free) begin
              cmd.emit        = EMIT_NOTE;
              cmd.wr_free_evt = 1'b1;
              state_nxt       = ST_IDLE;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        priority if (st.hit) begin
          if (st.out_free) begin
            cmd.emit         = EMIT_FLUSH;
            cmd.wr_free_scan = 1'b1;
            state_nxt        = ST_IDLE;
          end
        end else if (st.ptr_last) begin
          if (st.out_free) begin
            cmd.emit  = EMIT_DONE;
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit != EMIT_NONE |-> st.out_free)
    else $error("result issued while output register is full");

  a_capture_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == ST_EVT || state_r == ST_SCAN)
    else $error("accepted beat not processed");

  a_no_write_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !(cmd.wr_on || cmd.wr_free_evt || cmd.wr_free_scan))
    else $error("table write while idle");

endmodule

// ----- rtl/midi_note_pairing.sv -----
// Pairs MIDI note-on and note-off beats into notes (start, velocity, length in
// samples) using a 4096-entry table keyed by channel and note; control changes
// pass straight through, and a flush beat returns the next hanging note in
// ascending key order (cut at the take end) or a done result. After reset the
// block sweeps the table, one entry per cycle, with in_tready low; cfg is
// always ready. An event beat is accepted with a table read, then updates the
// table or issues a result, if any. A flush beat reads from the flush cursor upward,
// one table entry at a time through the single table read port, until a held
// note or the last entry. The result register lets the next beat start while
// a result waits; the block stalls only when a new result finds it still full.
module midi_note_pairing
  import mnp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // status_byte, first_data, second_data, sample_pos
  input  logic                   in_tuser,   // kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // channel, number, amount, start_pos, duration
  output logic [1:0]             out_tuser,  // result_kind
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [POS_BITS-1:0]    cfg_data    // take_length
);

  mnp_cmd_t  cmd;
  mnp_stat_t st;

  assign cfg_ready = 1'b1;

  mnp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  mnp_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .st         (st)
  );

endmodule
